>>> hdl/free_list_segment_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// free list allocator assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_SEGMENT_ALLOCATOR_CORE_ASSERT_SVH
`define FREE_LIST_SEGMENT_ALLOCATOR_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define FLSA_IMPLY(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define FLSA_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

>>> hdl/flsa_pkg.sv
// ----------------------------------------------------------------------------
// flsa_pkg
// shared types and constants of the free list segment allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package flsa_pkg;

  localparam int OFF_W       = 14;
  localparam int SIZE_W      = 15;
  localparam int REGION_MAX  = 16384;
  localparam int PAGE_BYTES  = 4096;
  localparam int ALIGN_BYTES = 8;
  localparam int MARK_DEPTH  = REGION_MAX / ALIGN_BYTES;
  localparam int MARK_AW     = $clog2(MARK_DEPTH);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ARGS = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_BAD_PTR  = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_BAD   = 2'd3;

  localparam logic CFG_REGION = 1'b0;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  start;
  } entry_t;

endpackage

>>> hdl/free_list_segment_allocator_core.sv
// ----------------------------------------------------------------------------
// free_list_segment_allocator_core
// explicit free list allocator, first / best / worst fit, with coalescing
// ----------------------------------------------------------------------------
// usage
//   in_* stream carries requests: tuser holds op and fit style, tdata holds
//   req_size and block_offset. out_* stream returns one result per request:
//   tdata the payload offset, tuser the status.
//   cfg_* apb port holds region_bytes at address 0; a write rounds it up to a
//   page, reloads the free table with one segment and starts a mark clear.
// table access
//   one request at a time through the free table memory port: an allocate
//   scan reads one table entry per cycle, as does a free scan, and an entry
//   inserted or dropped moves the entries above it, one entry moved per cycle.
//   count is at most MAX_FREE.
// reset and stalls
//   after reset and after each region write a clearing pass sweeps the 2048
//   block marks, one per cycle, with in_tready low. a stalled out channel
//   holds the result; one request may be accepted meanwhile, and its result
//   waits until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module free_list_segment_allocator_core
  import flsa_pkg::*;
#(
  parameter int MAX_FREE     = 512,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_size[14:0], block_offset[28:15], zero fill
  input  logic [31:0] in_tdata,
  // op[0], fit_style[2:1]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // payload_offset[13:0], zero fill
  output logic [15:0] out_tdata,
  // status[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

`include "free_list_segment_allocator_core_assert.svh"

  localparam int AW = $clog2(MAX_FREE);
  localparam int CW = $clog2(MAX_FREE + 1);
  localparam logic [16:0] HDR  = 17'(HEADER_BYTES);
  localparam logic [16:0] PAGE = 17'(PAGE_BYTES);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_ASCAN = 10'b0000000100,
    S_ATAKE = 10'b0000001000,
    S_MCHK  = 10'b0000010000,
    S_FSCAN = 10'b0000100000,
    S_FDEC  = 10'b0001000000,
    S_SHIFT = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   region_r, region_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [MARK_AW-1:0]  clr_idx_r, clr_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic [CW-1:0]       ridx_r, ridx_nxt;
  logic                found_r, found_nxt;
  logic                has_prev_r, has_prev_nxt;
  logic [CW-1:0]       sh_left_r, sh_left_nxt;

  logic [1:0]          fit_r, fit_nxt;
  logic [16:0]         need_r, need_nxt;
  logic [OFF_W-1:0]    h_r, h_nxt;
  logic [MARK_AW-1:0]  g_r, g_nxt;
  logic [SIZE_W-1:0]   sz_r, sz_nxt;
  logic [CW-1:0]       pick_r, pick_nxt;
  entry_t              best_r, best_nxt;
  entry_t              prev_r, prev_nxt;
  entry_t              right_r, right_nxt;
  logic [CW-1:0]       p_r, p_nxt;
  logic                sh_up_r, sh_up_nxt;
  logic [CW-1:0]       sh_rd_r, sh_rd_nxt;
  logic                post_we_r, post_we_nxt;
  logic [CW-1:0]       post_addr_r, post_addr_nxt;
  entry_t              post_data_r, post_data_nxt;
  logic                cnt_inc_r, cnt_inc_nxt;
  logic                cnt_dec_r, cnt_dec_nxt;
  logic [OFF_W-1:0]    res_pay_r, res_pay_nxt;
  logic [1:0]          res_st_r, res_st_nxt;
  logic [OFF_W-1:0]    out_pay_r, out_pay_nxt;
  logic [1:0]          out_st_r, out_st_nxt;

  entry_t              ft_mem [MAX_FREE];
  entry_t              ft_rd_r;
  logic [AW-1:0]       ft_raddr;
  logic                ft_we;
  logic [AW-1:0]       ft_waddr;
  entry_t              ft_wdata;

  logic [SIZE_W-1:0]   mark_mem [MARK_DEPTH];
  logic [SIZE_W-1:0]   mk_rd_r;
  logic [MARK_AW-1:0]  mk_raddr;
  logic                mk_we;
  logic [MARK_AW-1:0]  mk_waddr;
  logic [SIZE_W-1:0]   mk_wdata;

  logic                accept;
  logic                in_op;
  logic [1:0]          in_fit;
  logic [SIZE_W-1:0]   in_req;
  logic [OFF_W-1:0]    in_off;
  logic [16:0]         off_h;
  logic                cfg_wr;
  logic [16:0]         cfg_round;
  logic [SIZE_W-1:0]   cfg_region;
  logic                issue;
  logic                hit;
  logic                better;
  logic                last;
  logic                done;
  logic                split;
  logic                left_ok;
  logic                right_ok;

  assign in_op   = in_tuser[0];
  assign in_fit  = in_tuser[2:1];
  assign in_req  = in_tdata[14:0];
  assign in_off  = in_tdata[28:15];
  assign off_h   = {3'b000, in_off} - HDR;
  assign accept  = in_tvalid && in_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_pay_r};
  assign out_tuser  = out_st_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == CFG_REGION);
  assign cfg_prdata = (cfg_paddr[2] == CFG_REGION) ? {17'd0, region_r} : 32'd0;

  // round up to a page and saturate at the region limit
  assign cfg_round  = ({2'b00, cfg_pwdata[14:0]} + PAGE - 17'd1) & ~(PAGE - 17'd1);
  assign cfg_region = (cfg_round > 17'(REGION_MAX)) ? SIZE_W'(REGION_MAX)
                                                    : cfg_round[SIZE_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    region_nxt    = region_r;
    count_nxt     = count_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r;
    iss_nxt       = iss_r;
    rvalid_nxt    = 1'b0;
    ridx_nxt      = ridx_r;
    found_nxt     = found_r;
    has_prev_nxt  = has_prev_r;
    sh_left_nxt   = sh_left_r;
    fit_nxt       = fit_r;
    need_nxt      = need_r;
    h_nxt         = h_r;
    g_nxt         = g_r;
    sz_nxt        = sz_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    prev_nxt      = prev_r;
    right_nxt     = right_r;
    p_nxt         = p_r;
    sh_up_nxt     = sh_up_r;
    sh_rd_nxt     = sh_rd_r;
    post_we_nxt   = post_we_r;
    post_addr_nxt = post_addr_r;
    post_data_nxt = post_data_r;
    cnt_inc_nxt   = cnt_inc_r;
    cnt_dec_nxt   = cnt_dec_r;
    res_pay_nxt   = res_pay_r;
    res_st_nxt    = res_st_r;
    out_pay_nxt   = out_pay_r;
    out_st_nxt    = out_st_r;

    ft_raddr = iss_r[AW-1:0];
    ft_we    = 1'b0;
    ft_waddr = '0;
    ft_wdata = '0;
    mk_raddr = off_h[OFF_W-1:3];
    mk_we    = 1'b0;
    mk_waddr = g_r;
    mk_wdata = '0;

    issue    = 1'b0;
    hit      = ({2'b00, ft_rd_r.size} >= need_r);
    better   = !found_r || (fit_r == FIT_BEST && ft_rd_r.size < best_r.size) ||
               (fit_r == FIT_WORST && ft_rd_r.size > best_r.size);
    last     = (ridx_r == count_r - CW'(1));
    done     = 1'b0;
    split    = ({2'b00, best_r.size} >= need_r + HDR);
    left_ok  = has_prev_r &&
               ({3'b000, prev_r.start} + HDR + {2'b00, prev_r.size} == {3'b000, h_r});
    right_ok = (p_r < count_r) &&
               ({3'b000, h_r} + HDR + {2'b00, sz_r} == {3'b000, right_r.start});

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mk_we       = 1'b1;
        mk_waddr    = clr_idx_r;
        mk_wdata    = '0;
        clr_idx_nxt = clr_idx_r + MARK_AW'(1);
        if (clr_idx_r == MARK_AW'(MARK_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          res_pay_nxt = '0;
          fit_nxt     = in_fit;
          need_nxt    = ({2'b00, in_req} + 17'd7) & ~17'd7;
          iss_nxt     = '0;
          found_nxt   = 1'b0;
          has_prev_nxt = 1'b0;
          h_nxt       = off_h[OFF_W-1:0];
          g_nxt       = off_h[OFF_W-1:3];
          state_nxt   = S_RESP;
          if (in_op == OP_ALLOC) begin
            if (in_req == '0 || region_r == '0) begin
              res_st_nxt = ST_BAD_ARGS;
            end else if (in_fit == FIT_BAD || count_r == '0) begin
              res_st_nxt = ST_NO_SPACE;
            end else begin
              state_nxt = S_ASCAN;
            end
          end else begin
            if (in_off == '0) begin
              res_st_nxt = ST_OK;
            end else if (in_off < OFF_W'(HEADER_BYTES) || off_h[2:0] != 3'd0) begin
              res_st_nxt = ST_BAD_PTR;
            end else begin
              // mark read issued with the request
              state_nxt = S_MCHK;
            end
          end
        end
      end

      S_ASCAN: begin
        if (rvalid_r) begin
          if (hit && better) begin
            found_nxt = 1'b1;
            pick_nxt  = ridx_r;
            best_nxt  = ft_rd_r;
          end
          done = (fit_r == FIT_FIRST && hit) || last;
        end
        issue = (iss_r < count_r) && !done;
        if (issue) begin
          iss_nxt    = iss_r + CW'(1);
          rvalid_nxt = 1'b1;
          ridx_nxt   = iss_r;
        end
        if (done) begin
          if (found_r || hit) begin
            state_nxt = S_ATAKE;
          end else begin
            res_st_nxt = ST_NO_SPACE;
            state_nxt  = S_RESP;
          end
        end
      end

      S_ATAKE: begin
        res_st_nxt  = ST_OK;
        res_pay_nxt = OFF_W'({3'b000, best_r.start} + HDR);
        mk_we       = 1'b1;
        mk_waddr    = best_r.start[OFF_W-1:3];
        if (split) begin
          ft_we          = 1'b1;
          ft_waddr       = pick_r[AW-1:0];
          ft_wdata.start = OFF_W'({3'b000, best_r.start} + HDR + need_r);
          ft_wdata.size  = SIZE_W'({2'b00, best_r.size} - need_r - HDR);
          mk_wdata       = need_r[SIZE_W-1:0];
          state_nxt      = S_RESP;
        end else begin
          // taken whole: close the gap above the entry
          mk_wdata    = best_r.size;
          sh_up_nxt   = 1'b0;
          sh_rd_nxt   = pick_r + CW'(1);
          sh_left_nxt = count_r - pick_r - CW'(1);
          cnt_inc_nxt = 1'b0;
          cnt_dec_nxt = 1'b1;
          post_we_nxt = 1'b0;
          state_nxt   = S_SHIFT;
        end
      end

      S_MCHK: begin
        sz_nxt = mk_rd_r;
        if (mk_rd_r == '0) begin
          res_st_nxt = ST_BAD_PTR;
          state_nxt  = S_RESP;
        end else if (count_r == '0) begin
          p_nxt     = '0;
          state_nxt = S_FDEC;
        end else begin
          state_nxt = S_FSCAN;
        end
      end

      S_FSCAN: begin
        if (rvalid_r) begin
          if (ft_rd_r.start <= h_r) begin
            prev_nxt     = ft_rd_r;
            has_prev_nxt = 1'b1;
            if (last) begin
              p_nxt = count_r;
              done  = 1'b1;
            end
          end else begin
            right_nxt = ft_rd_r;
            p_nxt     = ridx_r;
            done      = 1'b1;
          end
        end
        issue = (iss_r < count_r) && !done;
        if (issue) begin
          iss_nxt    = iss_r + CW'(1);
          rvalid_nxt = 1'b1;
          ridx_nxt   = iss_r;
        end
        if (done) begin
          state_nxt = S_FDEC;
        end
      end

      S_FDEC: begin
        res_st_nxt = ST_OK;
        mk_waddr   = g_r;
        mk_wdata   = '0;
        state_nxt  = S_RESP;
        if (left_ok && right_ok) begin
          mk_we          = 1'b1;
          ft_we          = 1'b1;
          ft_waddr       = AW'(p_r - CW'(1));
          ft_wdata.start = prev_r.start;
          ft_wdata.size  = SIZE_W'({2'b00, prev_r.size} + HDR + HDR + {2'b00, sz_r} +
                                   {2'b00, right_r.size});
          sh_up_nxt      = 1'b0;
          sh_rd_nxt      = p_r + CW'(1);
          sh_left_nxt    = count_r - p_r - CW'(1);
          cnt_inc_nxt    = 1'b0;
          cnt_dec_nxt    = 1'b1;
          post_we_nxt    = 1'b0;
          state_nxt      = S_SHIFT;
        end else if (left_ok) begin
          mk_we          = 1'b1;
          ft_we          = 1'b1;
          ft_waddr       = AW'(p_r - CW'(1));
          ft_wdata.start = prev_r.start;
          ft_wdata.size  = SIZE_W'({2'b00, prev_r.size} + HDR + {2'b00, sz_r});
        end else if (right_ok) begin
          mk_we          = 1'b1;
          ft_we          = 1'b1;
          ft_waddr       = p_r[AW-1:0];
          ft_wdata.start = h_r;
          ft_wdata.size  = SIZE_W'({2'b00, right_r.size} + HDR + {2'b00, sz_r});
        end else if (count_r >= CW'(MAX_FREE)) begin
          // table full, block stays allocated
          res_st_nxt = ST_NO_SPACE;
        end else begin
          mk_we               = 1'b1;
          sh_up_nxt           = 1'b1;
          sh_rd_nxt           = count_r - CW'(1);
          sh_left_nxt         = count_r - p_r;
          cnt_inc_nxt         = 1'b1;
          cnt_dec_nxt         = 1'b0;
          post_we_nxt         = 1'b1;
          post_addr_nxt       = p_r;
          post_data_nxt.start = h_r;
          post_data_nxt.size  = sz_r;
          state_nxt           = S_SHIFT;
        end
      end

      S_SHIFT: begin
        ft_raddr = sh_rd_r[AW-1:0];
        issue    = (sh_left_r != '0);
        if (issue) begin
          sh_rd_nxt   = sh_up_r ? sh_rd_r - CW'(1) : sh_rd_r + CW'(1);
          sh_left_nxt = sh_left_r - CW'(1);
          rvalid_nxt  = 1'b1;
          ridx_nxt    = sh_rd_r;
        end
        if (rvalid_r) begin
          ft_we    = 1'b1;
          ft_waddr = sh_up_r ? AW'(ridx_r + CW'(1)) : AW'(ridx_r - CW'(1));
          ft_wdata = ft_rd_r;
        end
        if (!issue) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (post_we_r) begin
          ft_we    = 1'b1;
          ft_waddr = post_addr_r[AW-1:0];
          ft_wdata = post_data_r;
        end
        count_nxt = count_r + CW'(cnt_inc_r) - CW'(cnt_dec_r);
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pay_nxt   = res_pay_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // region write reloads the table and restarts the mark sweep
    if (cfg_wr) begin
      region_nxt     = cfg_region;
      count_nxt      = ({2'b00, cfg_region} > HDR) ? CW'(1) : CW'(0);
      ft_we          = 1'b1;
      ft_waddr       = '0;
      ft_wdata.start = '0;
      ft_wdata.size  = SIZE_W'({2'b00, cfg_region} - HDR);
      clr_idx_nxt    = '0;
      state_nxt      = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      region_r    <= '0;
      count_r     <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      rvalid_r    <= 1'b0;
      ridx_r      <= '0;
      found_r     <= 1'b0;
      has_prev_r  <= 1'b0;
      sh_left_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      region_r    <= region_nxt;
      count_r     <= count_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      rvalid_r    <= rvalid_nxt;
      ridx_r      <= ridx_nxt;
      found_r     <= found_nxt;
      has_prev_r  <= has_prev_nxt;
      sh_left_r   <= sh_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fit_r       <= fit_nxt;
    need_r      <= need_nxt;
    h_r         <= h_nxt;
    g_r         <= g_nxt;
    sz_r        <= sz_nxt;
    pick_r      <= pick_nxt;
    best_r      <= best_nxt;
    prev_r      <= prev_nxt;
    right_r     <= right_nxt;
    p_r         <= p_nxt;
    sh_up_r     <= sh_up_nxt;
    sh_rd_r     <= sh_rd_nxt;
    post_we_r   <= post_we_nxt;
    post_addr_r <= post_addr_nxt;
    post_data_r <= post_data_nxt;
    cnt_inc_r   <= cnt_inc_nxt;
    cnt_dec_r   <= cnt_dec_nxt;
    res_pay_r   <= res_pay_nxt;
    res_st_r    <= res_st_nxt;
    out_pay_r   <= out_pay_nxt;
    out_st_r    <= out_st_nxt;
  end

  // free segment table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ft_we) begin
      ft_mem[ft_waddr] <= ft_wdata;
    end
    ft_rd_r <= ft_mem[ft_raddr];
  end

  // block marks, one per 8-byte alignment granule
  always_ff @(posedge clk) begin
    if (mk_we) begin
      mark_mem[mk_waddr] <= mk_wdata;
    end
    mk_rd_r <= mark_mem[mk_raddr];
  end

  `FLSA_IMPLY(a_count_max, 1'b1, count_r <= CW'(MAX_FREE), "free count above table depth")
  `FLSA_IMPLY(a_scan_no_write, (state_r == S_ASCAN || state_r == S_FSCAN) && !cfg_wr,
              !ft_we, "free table written during a scan")
  `FLSA_IMPLY(a_payload_ok, out_valid_r && out_pay_r != '0, out_st_r == ST_OK,
              "payload offset returned with a failing status")
  `FLSA_NEXT(a_resp_to_idle, state_r == S_RESP && (!out_valid_r || out_tready) && !cfg_wr,
             out_valid_r && state_r == S_IDLE, "result not loaded into output register")

endmodule
